// ----- rtl/core/sddcr_pkg.sv -----
// Package for the SPI dual DAC command receiver.
// Holds phase codes, command bytes and the decode result type; no dependencies.
package sddcr_pkg;

  // Command bytes seen in a command phase.
  localparam logic [7:0] CMD_CHAN_A  = 8'h31;
  localparam logic [7:0] CMD_CHAN_B  = 8'h38;
  localparam logic [7:0] CMD_TWO_DEV = 8'h80;

  // Receive phase codes.
  localparam logic [3:0] PH_CMD_FIRST  = 4'd0;
  localparam logic [3:0] PH_C0_HI      = 4'd1;
  localparam logic [3:0] PH_C0_LO      = 4'd2;
  localparam logic [3:0] PH_C1_HI      = 4'd3;
  localparam logic [3:0] PH_C1_LO      = 4'd4;
  localparam logic [3:0] PH_C2_HI      = 4'd5;
  localparam logic [3:0] PH_C2_LO      = 4'd6;
  localparam logic [3:0] PH_C3_HI      = 4'd7;
  localparam logic [3:0] PH_C3_LO      = 4'd8;
  localparam logic [3:0] PH_CMD_SECOND = 4'd9;
  localparam logic [3:0] PH_SKIP1      = 4'd10;
  localparam logic [3:0] PH_SKIP2      = 4'd11;

  // What the decoder decides for one byte.
  typedef struct packed {
    logic [3:0] phase;      // next receive phase
    logic       high_load;  // byte is the high half of a value
    logic       two_set;    // switch to two-device mode
    logic       emit;       // byte completes a value
    logic [1:0] chan;       // channel of the completed value
  } dec_t;

endpackage

// ----- rtl/core/sddcr_decode.sv -----
// Per-byte phase decoder for the SPI dual DAC command receiver.
// Purely combinational; uses sddcr_pkg for codes and the dec_t result.
module sddcr_decode
  import sddcr_pkg::*;
(
  input  logic [3:0] phase,
  input  logic [7:0] data_byte,
  input  logic       two_devices,
  output dec_t       dec
);

  logic [1:0] lo_idx;

  // Low-byte phases 2, 4, 6 and 8 map to channels 0 to 3.
  assign lo_idx = phase[2:1] - 2'd1;

  always_comb begin
    dec = '0;
    dec.phase = phase;
    dec.chan = lo_idx;
    unique case (phase)
      PH_C0_HI, PH_C1_HI, PH_C2_HI, PH_C3_HI: begin
        dec.high_load = 1'b1;
        dec.phase = phase + 4'd1;
      end
      PH_C0_LO, PH_C1_LO, PH_C2_LO, PH_C3_LO: begin
        dec.emit = 1'b1;
        // A first-device write in two-device mode hands over to the second device.
        if (!lo_idx[1] && two_devices) begin
          dec.phase = PH_CMD_SECOND;
        end else begin
          dec.phase = PH_CMD_FIRST;
        end
      end
      PH_CMD_SECOND: begin
        priority if (data_byte == CMD_CHAN_A) begin
          dec.phase = PH_C2_HI;
        end else if (data_byte == CMD_CHAN_B) begin
          dec.phase = PH_C3_HI;
        end else if (data_byte == CMD_TWO_DEV) begin
          dec.two_set = 1'b1;
          dec.phase = PH_SKIP1;
        end else begin
          dec.phase = PH_CMD_SECOND;
        end
      end
      PH_SKIP1: begin
        dec.phase = PH_SKIP2;
      end
      PH_SKIP2: begin
        dec.phase = PH_CMD_FIRST;
      end
      default: begin
        // First device's command phase; unused codes behave the same way.
        priority if (data_byte == CMD_CHAN_A) begin
          dec.phase = PH_C0_HI;
        end else if (data_byte == CMD_CHAN_B) begin
          dec.phase = PH_C1_HI;
        end else if (data_byte == CMD_TWO_DEV) begin
          dec.two_set = 1'b1;
          dec.phase = PH_SKIP1;
        end else begin
          dec.phase = PH_CMD_FIRST;
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/spi_dual_dac_command_receiver.sv -----
// Top level of the SPI dual DAC command receiver.
// Uses sddcr_pkg and instantiates sddcr_decode.

// Takes one SPI byte per item and emits a channel/value item each time the
// low byte of a DAC write arrives. Bytes 0x31 and 0x38 select channel A or B,
// the next two bytes give the value high byte first, and 0x80 switches for
// good to two daisy-chained devices, where channels 2 and 3 belong to the
// second device. An item is registered on entry and then decoded into the
// output register, and one item is accepted every cycle while the output
// does not stall; each byte updates the single phase register. A stall on
// the output holds the pipeline and stalls the input.
module spi_dual_dac_command_receiver
  import sddcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_dac_channel,
  output logic [15:0] out_dac_value
);

  logic       byte_vld_r;
  logic [7:0] byte_r;
  logic [3:0] phase_r;
  logic [7:0] high_r;
  logic       two_dev_r;
  logic       out_vld_r;
  logic [1:0] out_chan_r;
  logic [15:0] out_val_r;
  logic       adv;
  dec_t       dec;

  // The decode stage moves whenever the output register is free or draining.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = byte_vld_r && !adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (!in_stall) begin
      byte_vld_r <= in_valid;
    end
    if (!in_stall) begin
      byte_r <= in_data_byte;
    end
  end

  sddcr_decode u_decode (
    .phase       (phase_r),
    .data_byte   (byte_r),
    .two_devices (two_dev_r),
    .dec         (dec)
  );

  // Receiver state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CMD_FIRST;
      high_r    <= 8'h00;
      two_dev_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= byte_vld_r && dec.emit;
      if (byte_vld_r) begin
        phase_r <= dec.phase;
        if (dec.high_load) begin
          high_r <= byte_r;
        end
        if (dec.two_set) begin
          two_dev_r <= 1'b1;
        end
      end
    end
    if (adv && byte_vld_r && dec.emit) begin
      out_chan_r <= dec.chan;
      out_val_r  <= {high_r, byte_r};
    end
  end

  assign out_valid       = out_vld_r;
  assign out_dac_channel = out_chan_r;
  assign out_dac_value   = out_val_r;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for spi_dual_dac_command_receiver: sends SPI bytes and checks each DAC write item.
// Depends on sddcr_pkg and the receiver RTL; it predicts each expected write on its own.

module tb;
  import sddcr_pkg::*;

  // One completed DAC write as it leaves the receiver.
  typedef struct {
    logic [1:0]  chan;
    logic [15:0] value;
  } dac_write_t;

  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_dac_channel;
  logic [15:0] out_dac_value;

  // Sender idle and receiver stall rates, in percent per cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;

  // Our own copy of the receiver state and the writes still to arrive.
  logic [3:0]  rx_phase = PH_CMD_FIRST;
  logic [7:0]  rx_high = 8'h00;
  logic        rx_two_dev = 1'b0;
  dac_write_t  expected_writes[$];

  spi_dual_dac_command_receiver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dac_channel (out_dac_channel),
    .out_dac_value   (out_dac_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode a command byte; hi_a and hi_b are the high-byte phases to enter.
  function automatic void decode_command(input logic [7:0] b, input logic [3:0] hi_a,
                                         input logic [3:0] hi_b);
    if (b == CMD_CHAN_A) begin
      rx_phase = hi_a;
    end else if (b == CMD_CHAN_B) begin
      rx_phase = hi_b;
    end else if (b == CMD_TWO_DEV) begin
      rx_two_dev = 1'b1;
      rx_phase = PH_SKIP1;
    end
  endfunction

  // Advance the predicted state by one byte and queue the write it completes.
  function automatic void track_spi_byte(input logic [7:0] b);
    dac_write_t w;
    logic [3:0] offs;
    case (rx_phase)
      PH_C0_HI, PH_C1_HI, PH_C2_HI, PH_C3_HI: begin
        rx_high = b;
        rx_phase = rx_phase + 4'd1;
      end
      PH_C0_LO, PH_C1_LO, PH_C2_LO, PH_C3_LO: begin
        offs = rx_phase - PH_C0_LO;
        w.chan = offs[2:1];
        w.value = {rx_high, b};
        expected_writes.push_back(w);
        rx_phase = (!w.chan[1] && rx_two_dev) ? PH_CMD_SECOND : PH_CMD_FIRST;
      end
      PH_CMD_SECOND: decode_command(b, PH_C2_HI, PH_C3_HI);
      PH_SKIP1: rx_phase = PH_SKIP2;
      PH_SKIP2: rx_phase = PH_CMD_FIRST;
      default: begin
        rx_phase = PH_CMD_FIRST;
        decode_command(b, PH_C0_HI, PH_C1_HI);
      end
    endcase
  endfunction

  // Every byte the receiver accepts feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      track_spi_byte(in_data_byte);
    end
  end

  // Compare each accepted write item with the oldest expected write.
  always @(posedge clk) begin
    dac_write_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, channel %0d value %h", $time,
                 out_dac_channel, out_dac_value);
        err_count++;
      end else begin
        w = expected_writes.pop_front();
        if (out_dac_channel !== w.chan) begin
          $display("%0t: channel mismatch, expected %0d actual %0d", $time,
                   w.chan, out_dac_channel);
          err_count++;
        end
        if (out_dac_value !== w.value) begin
          $display("%0t: value mismatch, expected %h actual %h", $time,
                   w.value, out_dac_value);
          err_count++;
        end
      end
    end
  end

  // Receiver back-pressure at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: done, errors");
    $finish;
  end

  // Send one byte, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A well-formed write: command byte, then the value high byte first.
  task automatic send_write(input logic [7:0] cmd, input logic [15:0] value);
    send_byte(cmd);
    send_byte(value[15:8]);
    send_byte(value[7:0]);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Single-device mode: unknown commands, value extremes, command bytes as data.
  task automatic test_single_device();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h7f);
    send_byte(8'h30);
    send_byte(8'h32);
    send_byte(8'h37);
    send_byte(8'h39);
    send_write(CMD_CHAN_A, 16'h0000);
    send_write(CMD_CHAN_B, 16'hffff);
    send_write(CMD_CHAN_A, {CMD_TWO_DEV, CMD_CHAN_A});
  endtask

  // Switch to two devices, then walk all four channels and both skip paths.
  task automatic test_two_device_switch();
    send_byte(CMD_TWO_DEV);
    send_byte(CMD_CHAN_A);
    send_byte(CMD_CHAN_B);
    send_write(CMD_CHAN_A, 16'h1234);
    // An unknown command while the second device is selected is ignored.
    send_byte(8'h55);
    send_write(CMD_CHAN_B, 16'ha55a);
    send_write(CMD_CHAN_B, 16'hfe01);
    send_write(CMD_CHAN_A, 16'h01fe);
    send_write(CMD_CHAN_A, 16'h0080);
    // Two-device command in the second device's phase skips two and returns to the first.
    send_byte(CMD_TWO_DEV);
    send_byte(8'haa);
    send_byte(8'h55);
    send_byte(CMD_TWO_DEV);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // Mostly well-formed writes with random content, plus noise and cut-off writes.
  task automatic test_random_writes(input int n_writes, input bit two_ok);
    int k;
    int pick;
    logic [7:0] b;
    for (k = 0; k < n_writes; k++) begin
      pick = $urandom_range(99);
      b = 8'($urandom);
      if (!two_ok && b == CMD_TWO_DEV) begin
        b = 8'h7f;
      end
      if (pick < 10) begin
        send_byte(b);
      end else if (pick < 16) begin
        // A write cut off after its high byte.
        send_byte($urandom_range(1) ? CMD_CHAN_B : CMD_CHAN_A);
        send_byte(b);
      end else if (two_ok && pick < 20) begin
        send_byte(CMD_TWO_DEV);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end
      send_write($urandom_range(1) ? CMD_CHAN_B : CMD_CHAN_A, 16'($urandom));
    end
  endtask

  initial begin
    set_idle(29, 54);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_device();
    test_random_writes(35, 1'b0);
    test_two_device_switch();
    test_random_writes(25, 1'b1);
    set_idle(54, 29);
    test_random_writes(25, 1'b1);
    set_idle(0, 0);
    test_random_writes(25, 1'b1);

    // Drain the outstanding writes, then keep watching the output for any further writes.
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0 && expected_writes.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
